@@ src/uvs_pkg.sv @@
// Package of the UV sphere vertex generator: shared widths, register and action codes,
// configuration and queue entry types, and the series divisor constants.
// No dependencies.
package uvs_pkg;

   localparam int DEF_MAX_SEGMENTS = 1024;
   localparam int DEF_ANGLE_BITS   = 16;

   localparam int SEG_W     = 11;
   localparam int IDX_W     = 21;
   localparam int POS_W     = 32;
   localparam int RAD_W     = 31;
   localparam int TEX_W     = 17;
   localparam int NORM_W    = 16;
   localparam int Q30_W     = 31;
   localparam int DEN_W     = SEG_W + 1;
   localparam int TEX_SHIFT = 17;
   localparam int TRIG_LAT  = 15;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [Q30_W-1:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [Q30_W-1:0] ONE_Q30     = 31'd1073741824;
   localparam logic [Q30_W-1:0] HALF_Q30    = 31'd536870912;

   localparam longint unsigned SIN_DIV [5] = '{6, 20, 42, 72, 110};
   localparam int              SIN_SH  [5] = '{35, 37, 38, 39, 39};
   localparam longint unsigned COS_DIV [6] = '{2, 12, 30, 56, 90, 132};
   localparam int              COS_SH  [6] = '{33, 36, 37, 38, 39, 40};

   typedef enum logic [2:0] {
      CSR_CENTER_X       = 3'd0,
      CSR_CENTER_Y       = 3'd1,
      CSR_CENTER_Z       = 3'd2,
      CSR_SPHERE_RADIUS  = 3'd3,
      CSR_LON_SEGMENTS   = 3'd4,
      CSR_LAT_SEGMENTS   = 3'd5,
      CSR_POSITION_ONLY  = 3'd6,
      CSR_REVERSE_NORMAL = 3'd7
   } csr_index_type;

   typedef enum logic {
      ACT_VERTEX = 1'b0,
      ACT_QUAD   = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [POS_W-1:0] center_x;
      logic signed [POS_W-1:0] center_y;
      logic signed [POS_W-1:0] center_z;
      logic [RAD_W-1:0]        radius;
      logic [SEG_W-1:0]        lon;
      logic [SEG_W-1:0]        lat;
      logic                    position_only;
      logic                    reverse_normal;
   } cfg_type;

   typedef struct packed {
      logic             quad;
      logic             last;
      logic [SEG_W-1:0] row;
      logic [SEG_W-1:0] col;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } entry_type;

   typedef struct packed {
      logic             valid;
      logic             quad;
      logic             last;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } side_type;

endpackage

@@ src/uvs_queue.sv @@
// Small register queue that carries classified items from the front to the back end.
// Depends on uvs_pkg for the entry type.
module uvs_queue import uvs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ff];
   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);

endmodule

@@ src/uvs_front.sv @@
// Front end: accepts items, clamps indices, computes quad corner indices and splits
// each quad into two triangle entries for the queue. Depends on uvs_pkg and uvs_queue.
module uvs_front import uvs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_action,
   input  logic [SEG_W-1:0] req_grid_row,
   input  logic [SEG_W-1:0] req_grid_col,
   input  logic             q_pop,
   output entry_type        q_data,
   output logic             q_empty
);
   logic             accept, q_full, push;
   logic             hold_valid_ff, hold_valid_in;
   entry_type        hold_ff, first_entry, second_entry, push_data;
   logic [SEG_W-1:0] lon_m1, lat_m1, row_q, col_q, row_v, col_v;
   logic [DEN_W-1:0] stride;
   logic [22:0]      i0, i1, i2, i3;

   always_comb begin
      lon_m1 = SEG_W'(cfg.lon - 1'b1);
      lat_m1 = SEG_W'(cfg.lat - 1'b1);
      row_q  = (req_grid_row > lat_m1) ? lat_m1 : req_grid_row;
      col_q  = (req_grid_col > lon_m1) ? lon_m1 : req_grid_col;
      row_v  = (req_grid_row > cfg.lat) ? cfg.lat : req_grid_row;
      col_v  = (req_grid_col > cfg.lon) ? cfg.lon : req_grid_col;
      stride = DEN_W'({1'b0, cfg.lon} + 1'b1);
      i0     = 23'(row_q * stride) + 23'(col_q);
      i1     = 23'(i0 + 1'b1);
      i2     = 23'(i0 + 23'(stride));
      i3     = 23'(i2 + 1'b1);

      first_entry  = '0;
      second_entry = '0;
      if (req_action == ACT_QUAD) begin
         first_entry.quad     = 1'b1;
         first_entry.last     = 1'b0;
         first_entry.corner_a = i0[IDX_W-1:0];
         first_entry.corner_b = i2[IDX_W-1:0];
         first_entry.corner_c = i1[IDX_W-1:0];
         second_entry.quad     = 1'b1;
         second_entry.last     = 1'b1;
         second_entry.corner_a = i1[IDX_W-1:0];
         second_entry.corner_b = i2[IDX_W-1:0];
         second_entry.corner_c = i3[IDX_W-1:0];
      end else begin
         first_entry.last = 1'b1;
         first_entry.row  = row_v;
         first_entry.col  = col_v;
      end
   end

   assign req_full = hold_valid_ff || q_full;
   assign accept   = req_push && !req_full;
   assign push     = (accept || hold_valid_ff) && !q_full;
   assign push_data = hold_valid_ff ? hold_ff : first_entry;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (push && hold_valid_ff) begin
         hold_valid_in = 1'b0;
      end else if (accept && req_action == ACT_QUAD) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= second_entry;
      end
   end

   uvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

endmodule

@@ src/uvs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a shared stall enable.
// Depends on uvs_pkg for the divisor width.
module uvs_div import uvs_pkg::*; #(
   parameter int NW = 29
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NW-1:0]    num,
   input  logic [DEN_W-1:0] den,
   output logic [NW-1:0]    quo
);
   logic [DEN_W-1:0] rem_ff [NW];
   logic [NW-1:0]    w_ff   [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev, rem_in;
      logic [NW-1:0]    w_prev, w_in;
      logic [DEN_W:0]   rem_sh;
      logic             ge;

      always_comb begin
         if (i == 0) begin
            rem_prev = '0;
            w_prev   = num;
         end else begin
            rem_prev = rem_ff[(i > 0) ? i - 1 : 0];
            w_prev   = w_ff[(i > 0) ? i - 1 : 0];
         end
         rem_sh = {rem_prev, w_prev[NW-1]};
         ge     = (rem_sh >= {1'b0, den});
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
         w_in   = {w_prev[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            w_ff[i]   <= w_in;
         end
      end
   end

   assign quo = w_ff[NW-1];

endmodule

@@ src/uvs_trig.sv @@
// Sine and cosine of an angle in turns: quadrant split, scaling to radians and a
// pipelined Taylor series, two stages per term. Depends on uvs_pkg.
module uvs_trig import uvs_pkg::*; #(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic [Q30_W-1:0]      sin_mag,
   output logic                  sin_neg,
   output logic [Q30_W-1:0]      cos_mag,
   output logic                  cos_neg
);
   localparam int RW    = ANGLE_BITS - 2;
   localparam int STEPS = 6;

   typedef struct packed {
      logic [31:0]        x2;
      logic [1:0]         quad;
      logic [31:0]        s_term;
      logic signed [33:0] s_acc;
      logic [31:0]        c_term;
      logic signed [33:0] c_acc;
   } ser_type;

   logic [Q30_W-1:0] x_ff;
   logic [1:0]       q1_ff;
   ser_type          init_ff;
   ser_type          a_ff [STEPS];
   ser_type          b_ff [STEPS];
   logic [Q30_W-1:0] s_cl, c_cl;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= Q30_W'((64'(angle[RW-1:0]) * 64'(HALF_PI_Q30)) >> RW);
         q1_ff <= angle[ANGLE_BITS-1 -: 2];
         init_ff.x2     <= 32'((64'(x_ff) * 64'(x_ff)) >> 30);
         init_ff.quad   <= q1_ff;
         init_ff.s_term <= 32'(x_ff);
         init_ff.s_acc  <= 34'(x_ff);
         init_ff.c_term <= 32'(ONE_Q30);
         init_ff.c_acc  <= 34'(ONE_Q30);
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [32:0] CM =
         33'(((64'd1 << COS_SH[k]) + COS_DIV[k] - 64'd1) / COS_DIV[k]);
      ser_type     prev, a_in, b_in;
      logic [64:0] c_prod, s_prod;
      logic [31:0] c_new, s_new;

      always_comb begin
         prev = (k == 0) ? init_ff : b_ff[(k > 0) ? k - 1 : 0];
         a_in = prev;
         a_in.c_term = 32'((64'(prev.c_term) * 64'(prev.x2)) >> 30);
         if (k < 5) begin
            a_in.s_term = 32'((64'(prev.s_term) * 64'(prev.x2)) >> 30);
         end
      end

      if (k < 5) begin : g_sin
         localparam logic [32:0] SM =
            33'(((64'd1 << SIN_SH[k]) + SIN_DIV[k] - 64'd1) / SIN_DIV[k]);
         assign s_prod = 65'(a_ff[k].s_term) * 65'(SM);
         assign s_new  = 32'(s_prod >> SIN_SH[k]);
      end else begin : g_pass
         assign s_prod = '0;
         assign s_new  = a_ff[k].s_term;
      end

      always_comb begin
         c_prod = 65'(a_ff[k].c_term) * 65'(CM);
         c_new  = 32'(c_prod >> COS_SH[k]);
         b_in   = a_ff[k];
         b_in.c_term = c_new;
         b_in.c_acc  = (k % 2 == 0) ? a_ff[k].c_acc - 34'(c_new) : a_ff[k].c_acc + 34'(c_new);
         if (k < 5) begin
            b_in.s_term = s_new;
            b_in.s_acc  = (k % 2 == 0) ? a_ff[k].s_acc - 34'(s_new)
                                       : a_ff[k].s_acc + 34'(s_new);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k] <= a_in;
            b_ff[k] <= b_in;
         end
      end
   end

   always_comb begin
      if (b_ff[STEPS-1].s_acc < 0) begin
         s_cl = '0;
      end else if (b_ff[STEPS-1].s_acc > 34'(ONE_Q30)) begin
         s_cl = ONE_Q30;
      end else begin
         s_cl = b_ff[STEPS-1].s_acc[Q30_W-1:0];
      end
      if (b_ff[STEPS-1].c_acc < 0) begin
         c_cl = '0;
      end else if (b_ff[STEPS-1].c_acc > 34'(ONE_Q30)) begin
         c_cl = ONE_Q30;
      end else begin
         c_cl = b_ff[STEPS-1].c_acc[Q30_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unique case (b_ff[STEPS-1].quad)
            2'd0: begin
               sin_mag <= s_cl; sin_neg <= 1'b0; cos_mag <= c_cl; cos_neg <= 1'b0;
            end
            2'd1: begin
               sin_mag <= c_cl; sin_neg <= 1'b0; cos_mag <= s_cl; cos_neg <= 1'b1;
            end
            2'd2: begin
               sin_mag <= s_cl; sin_neg <= 1'b1; cos_mag <= c_cl; cos_neg <= 1'b1;
            end
            default: begin
               sin_mag <= c_cl; sin_neg <= 1'b1; cos_mag <= s_cl; cos_neg <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ src/uvs_back.sv @@
// Back end: angle and texture division, sine and cosine, normal and position products,
// and the result register. The whole pipeline advances together when the result register
// is free or is being popped. Depends on uvs_pkg, uvs_div and uvs_trig.
module uvs_back import uvs_pkg::*; #(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  entry_type                q_data,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic signed [POS_W-1:0]  rsp_pos_z,
   output logic [TEX_W-1:0]         rsp_tex_u,
   output logic [TEX_W-1:0]         rsp_tex_v,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic [IDX_W-1:0]         rsp_corner_a,
   output logic [IDX_W-1:0]         rsp_corner_b,
   output logic [IDX_W-1:0]         rsp_corner_c,
   output logic                     rsp_last
);
   localparam int NW      = (ANGLE_BITS + 13 > TEX_SHIFT + DEN_W) ?
                            ANGLE_BITS + 13 : TEX_SHIFT + DEN_W;
   localparam int TEX_DLY = TRIG_LAT + 2;
   localparam int SB_LEN  = NW + TEX_DLY;

   logic              adv, out_valid_ff;
   side_type          sb_ff [SB_LEN + 1];
   logic [SEG_W-1:0]  row_ff, col_ff;
   logic [NW-1:0]     num_tt, num_tp, num_u, num_v, quo_tt, quo_tp, quo_u, quo_v;
   logic [DEN_W-1:0]  den_lat, den_lon;
   logic [TEX_W-1:0]  tu_ff [TEX_DLY];
   logic [TEX_W-1:0]  tv_ff [TEX_DLY];
   logic [Q30_W-1:0]  st_m, ct_m, sp_m, cp_m;
   logic              st_n, ct_n, sp_n, cp_n;
   logic [Q30_W-1:0]  nm1_ff [3];
   logic              nn1_ff [3];
   logic [Q30_W-1:0]  nm2_ff [3];
   logic              nn2_ff [3];
   logic [RAD_W-1:0]  d2_ff  [3];
   logic signed [POS_W-1:0] pos_in [3];
   logic signed [NORM_W-1:0] norm_in [3];
   logic signed [POS_W-1:0] center [3];

   assign adv       = !out_valid_ff || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SB_LEN; i++) begin
            sb_ff[i].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         sb_ff[0] <= '{valid: !q_empty, quad: q_data.quad, last: q_data.last,
                       corner_a: q_data.corner_a, corner_b: q_data.corner_b,
                       corner_c: q_data.corner_c};
         row_ff <= q_data.row;
         col_ff <= q_data.col;
         for (int i = 1; i <= SB_LEN; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
         out_valid_ff <= sb_ff[SB_LEN].valid;
      end
   end

   always_comb begin
      den_lat = {cfg.lat, 1'b0};
      den_lon = {cfg.lon, 1'b0};
      num_tt  = (NW'(row_ff) << ANGLE_BITS) + NW'(cfg.lat);
      num_tp  = (NW'(col_ff) << (ANGLE_BITS + 1)) + NW'(cfg.lon);
      num_u   = (NW'(col_ff) << TEX_SHIFT) + NW'(cfg.lon);
      num_v   = (NW'(row_ff) << TEX_SHIFT) + NW'(cfg.lat);
   end

   uvs_div #(.NW(NW)) u_div_tt (.clock(clock), .en(adv), .num(num_tt), .den(den_lat),
                                .quo(quo_tt));
   uvs_div #(.NW(NW)) u_div_tp (.clock(clock), .en(adv), .num(num_tp), .den(den_lon),
                                .quo(quo_tp));
   uvs_div #(.NW(NW)) u_div_u  (.clock(clock), .en(adv), .num(num_u), .den(den_lon),
                                .quo(quo_u));
   uvs_div #(.NW(NW)) u_div_v  (.clock(clock), .en(adv), .num(num_v), .den(den_lat),
                                .quo(quo_v));

   always_ff @(posedge clock) begin
      if (adv) begin
         tu_ff[0] <= quo_u[TEX_W-1:0];
         tv_ff[0] <= TEX_W'(18'd65536 - 18'(quo_v));
         for (int i = 1; i < TEX_DLY; i++) begin
            tu_ff[i] <= tu_ff[i-1];
            tv_ff[i] <= tv_ff[i-1];
         end
      end
   end

   uvs_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_theta (
      .clock(clock), .en(adv), .angle(quo_tt[ANGLE_BITS-1:0]),
      .sin_mag(st_m), .sin_neg(st_n), .cos_mag(ct_m), .cos_neg(ct_n)
   );

   uvs_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_phi (
      .clock(clock), .en(adv), .angle(quo_tp[ANGLE_BITS-1:0]),
      .sin_mag(sp_m), .sin_neg(sp_n), .cos_mag(cp_m), .cos_neg(cp_n)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         nm1_ff[0] <= Q30_W'((62'(st_m) * 62'(cp_m) + 62'(HALF_Q30)) >> 30);
         nm1_ff[1] <= Q30_W'((62'(st_m) * 62'(sp_m) + 62'(HALF_Q30)) >> 30);
         nm1_ff[2] <= ct_m;
         nn1_ff[0] <= (st_n != cp_n) ^ cfg.reverse_normal;
         nn1_ff[1] <= (st_n != sp_n) ^ cfg.reverse_normal;
         nn1_ff[2] <= ct_n ^ cfg.reverse_normal;
         for (int k = 0; k < 3; k++) begin
            d2_ff[k]  <= RAD_W'((62'(cfg.radius) * 62'(nm1_ff[k]) + 62'(HALF_Q30)) >> 30);
            nm2_ff[k] <= nm1_ff[k];
            nn2_ff[k] <= nn1_ff[k];
         end
      end
   end

   assign center[0] = cfg.center_x;
   assign center[1] = cfg.center_y;
   assign center[2] = cfg.center_z;

   for (genvar k = 0; k < 3; k++) begin : g_out
      logic signed [POS_W+1:0] p;
      logic [14:0]             m14;
      logic [14:0]             m14c;

      always_comb begin
         p = nn2_ff[k] ? (34'(center[k]) - 34'(d2_ff[k]))
                       : (34'(center[k]) + 34'(d2_ff[k]));
         if (p > 34'sd2147483647) begin
            pos_in[k] = 32'sh7FFFFFFF;
         end else if (p < -34'sd2147483648) begin
            pos_in[k] = 32'sh80000000;
         end else begin
            pos_in[k] = p[POS_W-1:0];
         end
         m14  = 15'((32'(nm2_ff[k]) + 32'd32768) >> 16);
         m14c = (m14 > 15'd16384) ? 15'd16384 : m14;
         norm_in[k] = nn2_ff[k] ? -$signed({1'b0, m14c}) : $signed({1'b0, m14c});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_corner_a <= sb_ff[SB_LEN].corner_a;
         rsp_corner_b <= sb_ff[SB_LEN].corner_b;
         rsp_corner_c <= sb_ff[SB_LEN].corner_c;
         rsp_last     <= sb_ff[SB_LEN].last;
         if (sb_ff[SB_LEN].quad) begin
            rsp_pos_x  <= '0;
            rsp_pos_y  <= '0;
            rsp_pos_z  <= '0;
            rsp_tex_u  <= '0;
            rsp_tex_v  <= '0;
            rsp_norm_x <= '0;
            rsp_norm_y <= '0;
            rsp_norm_z <= '0;
         end else begin
            rsp_pos_x <= pos_in[0];
            rsp_pos_y <= pos_in[1];
            rsp_pos_z <= pos_in[2];
            if (cfg.position_only) begin
               rsp_tex_u  <= '0;
               rsp_tex_v  <= '0;
               rsp_norm_x <= '0;
               rsp_norm_y <= '0;
               rsp_norm_z <= '0;
            end else begin
               rsp_tex_u  <= tu_ff[TEX_DLY-1];
               rsp_tex_v  <= tv_ff[TEX_DLY-1];
               rsp_norm_x <= norm_in[0];
               rsp_norm_y <= norm_in[1];
               rsp_norm_z <= norm_in[2];
            end
         end
      end
   end

endmodule

@@ src/uv_sphere_vertex_generator.sv @@
// Top level of the UV sphere vertex generator: configuration registers, front end and
// back end. Depends on uvs_pkg, uvs_front and uvs_back.
//
// Use: configuration is written through csr_valid, csr_index and csr_data while the block
// is idle; csr_ready is always high. Items enter through req_push while req_full is low.
// A vertex item gives one result; a quad item gives two triangles, the second with last set.
// Results wait on the rsp_ ports while rsp_empty is low and leave with rsp_pop.
// After a quad item req_full stays high until the front end has pushed the second of the
// two queue entries that it splits the quad into. The path from an item to its result
// runs through the one-bit-per-stage angle dividers of width NW, the larger of
// ANGLE_BITS + 13 and 29, and the two-stages-per-term sine series.
// Sustained rate is one result per cycle while rsp_pop stays high.
// Reset is synchronous and returns the registers to their reset values and empties the
// pipeline and the queue. When the receiver stalls, the whole back pipeline holds, the queue
// fills and req_full rises; nothing is lost.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_action,
   input  logic [SEG_W-1:0]         req_grid_row,
   input  logic [SEG_W-1:0]         req_grid_col,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic signed [POS_W-1:0]  rsp_pos_z,
   output logic [TEX_W-1:0]         rsp_tex_u,
   output logic [TEX_W-1:0]         rsp_tex_v,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic [IDX_W-1:0]         rsp_corner_a,
   output logic [IDX_W-1:0]         rsp_corner_b,
   output logic [IDX_W-1:0]         rsp_corner_c,
   output logic                     rsp_last
);
   logic signed [POS_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [SEG_W-1:0]        lon_ff, lat_ff;
   logic                    po_ff, rn_ff;
   cfg_type                 cfg;
   entry_type               q_data;
   logic                    q_empty, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= RAD_W'(65536);
         lon_ff <= SEG_W'(32);
         lat_ff <= SEG_W'(16);
         po_ff  <= 1'b0;
         rn_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:       cx_ff  <= csr_data;
            CSR_CENTER_Y:       cy_ff  <= csr_data;
            CSR_CENTER_Z:       cz_ff  <= csr_data;
            CSR_SPHERE_RADIUS:  rad_ff <= csr_data[RAD_W-1:0];
            CSR_LON_SEGMENTS:   lon_ff <= csr_data[SEG_W-1:0];
            CSR_LAT_SEGMENTS:   lat_ff <= csr_data[SEG_W-1:0];
            CSR_POSITION_ONLY:  po_ff  <= csr_data[0];
            CSR_REVERSE_NORMAL: rn_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.center_x       = cx_ff;
      cfg.center_y       = cy_ff;
      cfg.center_z       = cz_ff;
      cfg.radius         = rad_ff;
      cfg.position_only  = po_ff;
      cfg.reverse_normal = rn_ff;
      if (lon_ff == '0) begin
         cfg.lon = SEG_W'(1);
      end else if (32'(lon_ff) > MAX_SEGMENTS) begin
         cfg.lon = SEG_W'(MAX_SEGMENTS);
      end else begin
         cfg.lon = lon_ff;
      end
      if (lat_ff == '0) begin
         cfg.lat = SEG_W'(1);
      end else if (32'(lat_ff) > MAX_SEGMENTS) begin
         cfg.lat = SEG_W'(MAX_SEGMENTS);
      end else begin
         cfg.lat = lat_ff;
      end
   end

   uvs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_grid_row (req_grid_row),
      .req_grid_col (req_grid_col),
      .q_pop        (q_pop),
      .q_data       (q_data),
      .q_empty      (q_empty)
   );

   uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_data       (q_data),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .rsp_pos_z    (rsp_pos_z),
      .rsp_tex_u    (rsp_tex_u),
      .rsp_tex_v    (rsp_tex_v),
      .rsp_norm_x   (rsp_norm_x),
      .rsp_norm_y   (rsp_norm_y),
      .rsp_norm_z   (rsp_norm_z),
      .rsp_corner_a (rsp_corner_a),
      .rsp_corner_b (rsp_corner_b),
      .rsp_corner_c (rsp_corner_c),
      .rsp_last     (rsp_last)
   );

endmodule

@@ bench/uv_sphere_vertex_generator_checker.sv @@
// Checker of the UV sphere vertex generator: watches the register, item and result
// transfers, predicts every result and compares it as a whole. Depends on uvs_pkg.
`timescale 1ns / 100ps
module uv_sphere_vertex_generator_checker import uvs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic                     req_action,
   input  logic [SEG_W-1:0]         req_grid_row,
   input  logic [SEG_W-1:0]         req_grid_col,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic signed [POS_W-1:0]  rsp_pos_x,
   input  logic signed [POS_W-1:0]  rsp_pos_y,
   input  logic signed [POS_W-1:0]  rsp_pos_z,
   input  logic [TEX_W-1:0]         rsp_tex_u,
   input  logic [TEX_W-1:0]         rsp_tex_v,
   input  logic signed [NORM_W-1:0] rsp_norm_x,
   input  logic signed [NORM_W-1:0] rsp_norm_y,
   input  logic signed [NORM_W-1:0] rsp_norm_z,
   input  logic [IDX_W-1:0]         rsp_corner_a,
   input  logic [IDX_W-1:0]         rsp_corner_b,
   input  logic [IDX_W-1:0]         rsp_corner_c,
   input  logic                     rsp_last,
   output int                       fail_count,
   output int                       pending_vertices,
   output int                       results_seen
);

   typedef struct packed {
      logic [POS_W-1:0]  px, py, pz;
      logic [TEX_W-1:0]  tu, tv;
      logic [NORM_W-1:0] nx, ny, nz;
      logic [IDX_W-1:0]  ca, cb, cc;
      logic              last;
   } vertex_type;

   localparam longint unsigned ONE = 64'd1073741824;
   localparam int AB = DEF_ANGLE_BITS;

   cfg_type    sphere;
   vertex_type expected_vertices[$];

   function automatic longint unsigned clamp_unit(longint signed v);
      if (v < 0) return 0;
      if (v > longint'(ONE)) return ONE;
      return longint'(v);
   endfunction

   function automatic longint unsigned series_sine(longint unsigned x);
      longint unsigned x2, term;
      longint signed acc;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k & 1) acc -= term; else acc += term;
      end
      return clamp_unit(acc);
   endfunction

   function automatic longint unsigned series_cosine(longint unsigned x);
      longint unsigned x2, term;
      longint signed acc;
      x2 = (x * x) >> 30;
      term = ONE;
      acc = ONE;
      for (int k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
         if (k & 1) acc -= term; else acc += term;
      end
      return clamp_unit(acc);
   endfunction

   task automatic turn_trig(input longint unsigned t, output longint unsigned sm,
                            output bit sn, output longint unsigned cm, output bit cn);
      longint unsigned r, x, s, c;
      r = t & ((64'd1 << (AB - 2)) - 1);
      x = (r * 64'd1686629713) >> (AB - 2);
      s = series_sine(x);
      c = series_cosine(x);
      case ((t >> (AB - 2)) & 3)
         0: begin sm = s; sn = 0; cm = c; cn = 0; end
         1: begin sm = c; sn = 0; cm = s; cn = 1; end
         2: begin sm = s; sn = 1; cm = c; cn = 1; end
         default: begin sm = c; sn = 1; cm = s; cn = 0; end
      endcase
   endtask

   function automatic longint unsigned used_segments(logic [SEG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_SEGMENTS) return DEF_MAX_SEGMENTS;
      return v;
   endfunction

   function automatic logic [POS_W-1:0] offset_position(logic signed [POS_W-1:0] c,
                                                        longint unsigned nm, bit neg);
      longint unsigned d;
      longint signed p;
      d = (longint'(sphere.radius) * nm + (64'd1 << 29)) >> 30;
      p = neg ? longint'(c) - longint'(d) : longint'(c) + longint'(d);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[POS_W-1:0];
   endfunction

   task automatic predict_item(bit quad, longint unsigned row, longint unsigned col);
      longint unsigned lon, lat, stride, i0, tt, tp, stm, ctm, spm, cpm, m14;
      longint unsigned nm[3];
      bit stn, ctn, spn, cpn;
      bit nn[3];
      vertex_type v;
      lon = used_segments(sphere.lon);
      lat = used_segments(sphere.lat);
      v = '0;
      if (quad) begin
         if (row > lat - 1) row = lat - 1;
         if (col > lon - 1) col = lon - 1;
         stride = lon + 1;
         i0 = row * stride + col;
         v.ca = IDX_W'(i0);
         v.cb = IDX_W'(i0 + stride);
         v.cc = IDX_W'(i0 + 1);
         v.last = 1'b0;
         expected_vertices = {expected_vertices, v};
         v.ca = IDX_W'(i0 + 1);
         v.cb = IDX_W'(i0 + stride);
         v.cc = IDX_W'(i0 + stride + 1);
         v.last = 1'b1;
         expected_vertices = {expected_vertices, v};
      end else begin
         if (row > lat) row = lat;
         if (col > lon) col = lon;
         tt = ((row << AB) + lat) / (2 * lat);
         tp = (((col << (AB + 1)) + lon) / (2 * lon)) & ((64'd1 << AB) - 1);
         turn_trig(tt, stm, stn, ctm, ctn);
         turn_trig(tp, spm, spn, cpm, cpn);
         nm[0] = (stm * cpm + (64'd1 << 29)) >> 30; nn[0] = stn != cpn;
         nm[1] = (stm * spm + (64'd1 << 29)) >> 30; nn[1] = stn != spn;
         nm[2] = ctm; nn[2] = ctn;
         if (sphere.reverse_normal)
            for (int k = 0; k < 3; k++) nn[k] = !nn[k];
         v.px = offset_position(sphere.center_x, nm[0], nn[0]);
         v.py = offset_position(sphere.center_y, nm[1], nn[1]);
         v.pz = offset_position(sphere.center_z, nm[2], nn[2]);
         if (!sphere.position_only) begin
            v.tu = TEX_W'((col * 131072 + lon) / (2 * lon));
            v.tv = TEX_W'(65536 - (row * 131072 + lat) / (2 * lat));
            for (int k = 0; k < 3; k++) begin
               m14 = (nm[k] + 32768) >> 16;
               if (m14 > 16384) m14 = 16384;
               m14 = nn[k] ? -m14 : m14;
               if (k == 0) v.nx = NORM_W'(m14);
               else if (k == 1) v.ny = NORM_W'(m14);
               else v.nz = NORM_W'(m14);
            end
         end
         v.last = 1'b1;
         expected_vertices = {expected_vertices, v};
      end
   endtask

   always @(posedge clock) begin
      vertex_type got, want;
      if (reset) begin
         sphere <= '{'0, '0, '0, RAD_W'(65536), SEG_W'(32), SEG_W'(16), 1'b0, 1'b0};
         expected_vertices.delete();
         fail_count <= 0;
         results_seen <= 0;
         pending_vertices <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER_X:       sphere.center_x <= csr_data;
               CSR_CENTER_Y:       sphere.center_y <= csr_data;
               CSR_CENTER_Z:       sphere.center_z <= csr_data;
               CSR_SPHERE_RADIUS:  sphere.radius <= csr_data[RAD_W-1:0];
               CSR_LON_SEGMENTS:   sphere.lon <= csr_data[SEG_W-1:0];
               CSR_LAT_SEGMENTS:   sphere.lat <= csr_data[SEG_W-1:0];
               CSR_POSITION_ONLY:  sphere.position_only <= csr_data[0];
               CSR_REVERSE_NORMAL: sphere.reverse_normal <= csr_data[0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            predict_item(req_action == ACT_QUAD, req_grid_row, req_grid_col);
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u, rsp_tex_v, rsp_norm_x,
                    rsp_norm_y, rsp_norm_z, rsp_corner_a, rsp_corner_b, rsp_corner_c,
                    rsp_last};
            results_seen <= results_seen + 1;
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_vertices.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_vertices <= expected_vertices.size();
      end
   end

endmodule

@@ bench/uv_sphere_vertex_generator_tb.sv @@
// Top of the UV sphere vertex generator testbench: clock, reset, register writes, item
// stimulus with idling phases, and the verdict. Depends on uvs_pkg, the generator and the checker module.
`timescale 1ns / 100ps
module uv_sphere_vertex_generator_tb import uvs_pkg::*;;

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   logic req_push = 0, req_full, req_action = 0;
   logic [SEG_W-1:0] req_grid_row = 0, req_grid_col = 0;
   logic rsp_empty, rsp_pop = 0, rsp_last;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic signed [NORM_W-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [IDX_W-1:0] rsp_corner_a, rsp_corner_b, rsp_corner_c;
   int fail_count, pending_vertices, results_seen;
   int send_idle_pct = 0, pop_stall_pct = 0, items_sent = 0;
   longint cycle_count = 0;

   uv_sphere_vertex_generator dut (.*);
   uv_sphere_vertex_generator_checker checker_inst (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      if (cycle_count > 3000000) begin
         $display("uv_sphere_vertex_generator_tb NOT OK");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_item(action_type act, int row, int col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_action <= act;
      req_grid_row <= SEG_W'(row);
      req_grid_col <= SEG_W'(col);
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic drain_all();
      req_push <= 0;
      repeat (2) @(posedge clock);
      while (pending_vertices != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_items(int count, int lon, int lat);
      int row, col;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: begin row = $urandom_range(2047); col = $urandom_range(2047); end
            1: begin row = $urandom_range(1) * lat; col = $urandom_range(1) * lon; end
            default: begin row = $urandom_range(lat + 1); col = $urandom_range(lon + 1); end
         endcase
         send_item(action_type'($urandom_range(1)), row, col);
      end
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, int lon, int lat, bit ponly, bit rev);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_CENTER_Z, cz);
      write_reg(CSR_SPHERE_RADIUS, rad);
      write_reg(CSR_LON_SEGMENTS, lon);
      write_reg(CSR_LAT_SEGMENTS, lat);
      write_reg(CSR_POSITION_ONLY, 32'(ponly));
      write_reg(CSR_REVERSE_NORMAL, 32'(rev));
      csr_valid <= 0;
   endtask

   initial begin
      int lon, lat;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int r = 0; r <= 17; r += 4) send_item(ACT_VERTEX, r, r * 2);
      send_item(ACT_VERTEX, 2047, 2047);
      send_item(ACT_VERTEX, 16, 32);
      send_item(ACT_QUAD, 0, 0);
      send_item(ACT_QUAD, 15, 31);
      send_item(ACT_QUAD, 2047, 2047);
      send_item(ACT_VERTEX, 1024, 1024);
      drain_all();

      set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_FFFF,
                 0, 0, 1, 1);
      send_item(ACT_VERTEX, 0, 0);
      send_item(ACT_VERTEX, 1, 1);
      send_item(ACT_QUAD, 3, 3);
      drain_all();
      set_sphere(32'hFFFF_0000, 0, 32'h0001_8000, 0, 2047, 2047, 0, 1);
      send_item(ACT_VERTEX, 1024, 1024);
      send_item(ACT_VERTEX, 512, 333);
      send_item(ACT_QUAD, 1023, 1023);
      send_item(ACT_QUAD, 2047, 0);
      drain_all();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 72; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 72; end
            default: begin send_idle_pct = 38; pop_stall_pct = 38; end
         endcase
         lon = (phase == 4) ? 1024 : $urandom_range(1, 40);
         lat = (phase == 5) ? 1024 : $urandom_range(1, 40);
         set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(31),
                    lon, lat, 1'($urandom_range(1)), 1'($urandom_range(1)));
         random_items(245, lon, lat);
         drain_all();
      end

      send_idle_pct = 0;
      pop_stall_pct = 0;
      drain_all();
      $display("Sent %0d items over nine register settings and four idling mixes;", items_sent);
      $display("%0d results were checked.", results_seen);
      if (fail_count == 0) begin
         $display("uv_sphere_vertex_generator_tb OK");
      end else begin
         $display("uv_sphere_vertex_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
